[rtl/core/eire_pkg.sv]
// Package: types, constants and helpers of the extremal index runs estimator.
`timescale 1ns / 1ps
package eire_pkg;

    localparam int SAMPLE_WIDTH       = 32;
    localparam int COUNT_WIDTH        = 32;
    localparam int ESTIMATE_FRAC_BITS = 16;
    localparam int GAP_WIDTH          = 16;
    localparam int CFG_INDEX_WIDTH    = 8;
    localparam int CFG_DATA_WIDTH     = 32;
    localparam int EST_WIDTH          = ESTIMATE_FRAC_BITS + 1;
    localparam int DIV_CNT_WIDTH      = $clog2(ESTIMATE_FRAC_BITS + 1);
    localparam int QUEUE_DEPTH        = 2;
    localparam int QPTR_WIDTH         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_THRESHOLD = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_GAP   = CFG_INDEX_WIDTH'(1);

    localparam logic REC_CLUSTER  = 1'b0;
    localparam logic REC_ESTIMATE = 1'b1;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           last;
    } in_t;

    typedef struct packed {
        logic                   kind;
        logic [COUNT_WIDTH-1:0] cluster_size;
        logic [EST_WIDTH-1:0]   estimate;
        logic                   no_exceedances;
        logic                   end_of_series;
    } out_t;

    // Work handed from the front to the back for one sample.
    typedef struct packed {
        logic   close_a;
        count_t size_a;
        logic   last;
        logic   any;
        count_t size_b;
        count_t clusters;
        count_t exceeds;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CLOSE_A,
        BK_CLOSE_B,
        BK_DIV,
        BK_EST
    } back_state_t;

    function automatic count_t sat_inc(input count_t v);
        sat_inc = (v == '1) ? v : v + count_t'(1);
    endfunction

endpackage

[rtl/core/eire_front.sv]
// Front end: threshold compare, cluster tracking and command generation per sample.
`timescale 1ns / 1ps
module eire_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_ready,
    input  eire_pkg::in_t                          item,
    input  logic signed [eire_pkg::SAMPLE_WIDTH-1:0] threshold,
    input  logic [eire_pkg::GAP_WIDTH-1:0]         max_gap,
    input  logic                                   queue_full,
    output logic                                   push,
    output eire_pkg::cmd_t                         cmd
);
    import eire_pkg::*;

    count_t index_reg,    index_next;
    count_t prev_reg,     prev_next;
    count_t open_reg,     open_next;
    count_t clusters_reg, clusters_next;
    count_t exceeds_reg,  exceeds_next;
    logic   any_reg,      any_next;

    logic   accept;
    logic   exceed;
    logic   join_open;
    count_t gap;
    count_t open_upd;
    count_t clusters_upd;
    count_t exceeds_upd;
    logic   any_upd;

    assign item_ready = !queue_full;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        exceed       = item.sample > threshold;
        gap          = index_reg - prev_reg;
        join_open    = any_reg && (gap <= COUNT_WIDTH'(max_gap));
        open_upd     = open_reg;
        clusters_upd = clusters_reg;
        exceeds_upd  = exceeds_reg;
        if (exceed)
        begin
            exceeds_upd = sat_inc(exceeds_reg);
            if (join_open)
            begin
                open_upd = sat_inc(open_reg);
            end
            else
            begin
                open_upd     = count_t'(1);
                clusters_upd = sat_inc(clusters_reg);
            end
        end
        any_upd = any_reg || exceed;

        cmd.close_a  = exceed && !join_open && any_reg;
        cmd.size_a   = open_reg;
        cmd.last     = item.last;
        cmd.any      = any_upd;
        cmd.size_b   = open_upd;
        cmd.clusters = clusters_upd;
        cmd.exceeds  = exceeds_upd;
        push         = accept && (cmd.close_a || item.last);

        index_next    = index_reg;
        prev_next     = prev_reg;
        open_next     = open_reg;
        clusters_next = clusters_reg;
        exceeds_next  = exceeds_reg;
        any_next      = any_reg;
        if (accept)
        begin
            if (item.last)
            begin
                index_next    = '0;
                prev_next     = '0;
                open_next     = '0;
                clusters_next = '0;
                exceeds_next  = '0;
                any_next      = 1'b0;
            end
            else
            begin
                index_next    = index_reg + count_t'(1);
                prev_next     = exceed ? index_reg : prev_reg;
                open_next     = open_upd;
                clusters_next = clusters_upd;
                exceeds_next  = exceeds_upd;
                any_next      = any_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg    <= '0;
            prev_reg     <= '0;
            open_reg     <= '0;
            clusters_reg <= '0;
            exceeds_reg  <= '0;
            any_reg      <= 1'b0;
        end
        else
        begin
            index_reg    <= index_next;
            prev_reg     <= prev_next;
            open_reg     <= open_next;
            clusters_reg <= clusters_next;
            exceeds_reg  <= exceeds_next;
            any_reg      <= any_next;
        end
    end

endmodule

[rtl/core/eire_queue.sv]
// Command queue between front and back.
`timescale 1ns / 1ps
module eire_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  eire_pkg::cmd_t push_cmd,
    input  logic           pop,
    output eire_pkg::cmd_t head,
    output logic           empty,
    output logic           full
);
    import eire_pkg::*;

    cmd_t                  entry_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_WIDTH-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_WIDTH-1:0] count_reg,  count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_WIDTH'(QUEUE_DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_WIDTH'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_WIDTH'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_WIDTH'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/core/eire_back.sv]
// Back end: emits cluster records, runs the serial divider, emits the estimate record.
`timescale 1ns / 1ps
module eire_back (
    input  logic           clk,
    input  logic           rst_n,
    input  eire_pkg::cmd_t head,
    input  logic           empty,
    output logic           pop,
    output logic           result_valid,
    input  logic           result_ready,
    output eire_pkg::out_t result
);
    import eire_pkg::*;

    back_state_t              state_reg, state_next;
    cmd_t                     cmd_reg,   cmd_next;
    count_t                   rem_reg,   rem_next;
    logic [EST_WIDTH-1:0]     quo_reg,   quo_next;
    logic [DIV_CNT_WIDTH-1:0] bit_reg,   bit_next;
    logic                     out_valid_reg, out_valid_next;
    out_t                     out_reg,   out_next;

    logic                     out_load;
    logic [COUNT_WIDTH:0]     rem_dbl;
    logic                     rem_ge;
    logic [EST_WIDTH-1:0]     est_rounded;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign out_load     = !out_valid_reg || result_ready;

    always_comb
    begin
        rem_dbl     = {rem_reg, 1'b0};
        rem_ge      = rem_dbl >= {1'b0, cmd_reg.exceeds};
        est_rounded = quo_reg + EST_WIDTH'(rem_ge);

        state_next     = state_reg;
        cmd_next       = cmd_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        bit_next       = bit_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result_ready;
        pop            = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    if (head.close_a)
                    begin
                        state_next = BK_CLOSE_A;
                    end
                    else if (head.any)
                    begin
                        state_next = BK_CLOSE_B;
                    end
                    else
                    begin
                        state_next = BK_EST;
                    end
                end
            end
            BK_CLOSE_A:
            begin
                if (out_load)
                begin
                    out_valid_next          = 1'b1;
                    out_next.kind           = REC_CLUSTER;
                    out_next.cluster_size   = cmd_reg.size_a;
                    out_next.estimate       = '0;
                    out_next.no_exceedances = 1'b0;
                    out_next.end_of_series  = 1'b0;
                    if (!cmd_reg.last)
                    begin
                        state_next = BK_IDLE;
                    end
                    else if (cmd_reg.any)
                    begin
                        state_next = BK_CLOSE_B;
                    end
                    else
                    begin
                        state_next = BK_EST;
                    end
                end
            end
            BK_CLOSE_B:
            begin
                if (out_load)
                begin
                    out_valid_next          = 1'b1;
                    out_next.kind           = REC_CLUSTER;
                    out_next.cluster_size   = cmd_reg.size_b;
                    out_next.estimate       = '0;
                    out_next.no_exceedances = 1'b0;
                    out_next.end_of_series  = 1'b0;
                    // clusters never exceed exceedances: integer part is 1 only on equality
                    if (cmd_reg.clusters == cmd_reg.exceeds)
                    begin
                        quo_next = EST_WIDTH'(1);
                        rem_next = '0;
                    end
                    else
                    begin
                        quo_next = '0;
                        rem_next = cmd_reg.clusters;
                    end
                    bit_next   = '0;
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (rem_ge)
                begin
                    rem_next = count_t'(rem_dbl - {1'b0, cmd_reg.exceeds});
                    quo_next = {quo_reg[EST_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next = count_t'(rem_dbl);
                    quo_next = {quo_reg[EST_WIDTH-2:0], 1'b0};
                end
                bit_next = bit_reg + DIV_CNT_WIDTH'(1);
                if (bit_reg == DIV_CNT_WIDTH'(ESTIMATE_FRAC_BITS - 1))
                begin
                    state_next = BK_EST;
                end
            end
            BK_EST:
            begin
                if (out_load)
                begin
                    out_valid_next          = 1'b1;
                    out_next.kind           = REC_ESTIMATE;
                    out_next.cluster_size   = '0;
                    out_next.estimate       = cmd_reg.any ? est_rounded : '0;
                    out_next.no_exceedances = !cmd_reg.any;
                    out_next.end_of_series  = 1'b1;
                    state_next              = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            bit_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_reg       <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        out_reg <= out_next;
    end

endmodule

[rtl/core/extremal_index_runs_estimator_unit.sv]
// Top level: configuration registers, front end, command queue and back end.
// Input: one sample a cycle while the two-entry command queue has room.
// Output: a cluster record needs a queue pop and then an output load in the back end; the
// estimate record follows the series' last cluster record and, if there were exceedances,
// the serial divider's fraction bits. Records also wait on back-end busy and output stalls.
// Reset (rst_n, async low): series state cleared, threshold 0, max_gap 1, queue empty.
`timescale 1ns / 1ps
module extremal_index_runs_estimator_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [eire_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [eire_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    input  logic                                   sample_valid,
    output logic                                   sample_ready,
    input  eire_pkg::in_t                          sample_item,
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output eire_pkg::out_t                         result_item
);
    import eire_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] threshold_reg;
    logic [GAP_WIDTH-1:0]           max_gap_reg;

    logic queue_full;
    logic queue_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            max_gap_reg   <= GAP_WIDTH'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= SAMPLE_WIDTH'(cfg_data);
                CFG_MAX_GAP:   max_gap_reg   <= cfg_data[GAP_WIDTH-1:0];
                default:       ;
            endcase
        end
    end

    eire_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (sample_valid),
        .item_ready (sample_ready),
        .item       (sample_item),
        .threshold  (threshold_reg),
        .max_gap    (max_gap_reg),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    eire_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    eire_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (queue_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_item)
    );

endmodule
